// ===== rtl/core/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the syntax color classifier
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_STAR  = 8'd42;

	// configuration register indexes
	localparam logic [1:0] CFG_SEL_START_ROW = 2'd0;
	localparam logic [1:0] CFG_SEL_START_COL = 2'd1;
	localparam logic [1:0] CFG_SEL_END_ROW   = 2'd2;
	localparam logic [1:0] CFG_SEL_END_COL   = 2'd3;

	typedef enum logic [1:0] {
		CLS_NORMAL  = 2'd0,
		CLS_PUNCT   = 2'd1,
		CLS_COMMENT = 2'd2
	} scc_class_t;

	typedef struct packed {
		logic [7:0]  char_code;
		logic [7:0]  next_code;
		logic [15:0] line_index;
		logic [15:0] col_index;
		logic        frame_first;
		logic        line_first;
	} scc_in_t;

	typedef struct packed {
		scc_class_t fg_class;
		logic       selected;
	} scc_out_t;

	typedef struct packed {
		logic       in_line_comment;
		logic       in_block_comment;
		logic [7:0] prev_char;
	} scc_lex_state_t;

	typedef struct packed {
		logic [15:0] start_row;
		logic [15:0] start_col;
		logic [15:0] end_row;
		logic [15:0] end_col;
	} scc_sel_cfg_t;

endpackage

// ===== rtl/core/syntax_color_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// syntax_color_classifier_unit
// Per-character foreground class and selection flag for a text renderer
// ----------------------------------------------------------------------------
// each character passes through the input register and then the result register;
// comment state is registered as the character moves into the result register
// throughput: one character per cycle while the output is not stalled
// two characters can be held; with both held, a stalled output drops in_ready
// reset clears both comment flags, the previous character, the selection
// registers and all valid flags
module syntax_color_classifier_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scc_pkg::scc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output scc_pkg::scc_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import scc_pkg::*;

	scc_in_t        data_s1;
	logic           valid_s1;
	scc_out_t       data_s2;
	logic           valid_s2;
	scc_lex_state_t lex_q;
	scc_lex_state_t lex_next;
	scc_sel_cfg_t   sel_cfg_q;
	scc_class_t     cls;
	logic           sel_hit;
	logic           adv_s2;

	assign adv_s2    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s2;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEL_START_ROW: sel_cfg_q.start_row <= cfg_data;
				CFG_SEL_START_COL: sel_cfg_q.start_col <= cfg_data;
				CFG_SEL_END_ROW:   sel_cfg_q.end_row   <= cfg_data;
				CFG_SEL_END_COL:   sel_cfg_q.end_col   <= cfg_data;
				default:           sel_cfg_q           <= sel_cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	scc_classify u_classify (
		.cur_state   (lex_q),
		.char_code   (data_s1.char_code),
		.next_code   (data_s1.next_code),
		.frame_first (data_s1.frame_first),
		.line_first  (data_s1.line_first),
		.fg_class    (cls),
		.next_state  (lex_next)
	);

	scc_select u_select (
		.sel_cfg    (sel_cfg_q),
		.line_index (data_s1.line_index),
		.col_index  (data_s1.col_index),
		.selected   (sel_hit)
	);

	// comment state commits when the character moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) begin
				lex_q <= lex_next;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			data_s2.fg_class <= cls;
			data_s2.selected <= sel_hit;
		end
	end

	// full pipeline with a stalled output holds off new input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted while both stages are held");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> out_valid)
		else $error("result register not loaded after stage advance");

	a_prev_char: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> (lex_q.prev_char == $past(data_s1.char_code)))
		else $error("previous character not tracked");

	// an open comment can only leave a character classed as comment
	a_cmt_class: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> (!(lex_q.in_line_comment || lex_q.in_block_comment) ||
			(out_data.fg_class == CLS_COMMENT)))
		else $error("open comment after a non-comment character");

endmodule

// ===== rtl/core/scc_classify.sv =====
// ----------------------------------------------------------------------------
// scc_classify
// Comment tracking and foreground class of one character
// ----------------------------------------------------------------------------
module scc_classify (
	input  scc_pkg::scc_lex_state_t cur_state,
	input  logic [7:0]              char_code,
	input  logic [7:0]              next_code,
	input  logic                    frame_first,
	input  logic                    line_first,
	output scc_pkg::scc_class_t     fg_class,
	output scc_pkg::scc_lex_state_t next_state
);
	import scc_pkg::*;

	logic       line_cmt;
	logic       block_cmt;
	logic [7:0] prev;
	logic       punct;

	always_comb begin
		punct = char_code inside {[8'd33:8'd47], [8'd60:8'd62], [8'd91:8'd94],
			[8'd123:8'd125]};
	end

	always_comb begin
		// frame start drops both comments, line start drops the line comment
		line_cmt  = cur_state.in_line_comment & ~frame_first & ~line_first;
		block_cmt = cur_state.in_block_comment & ~frame_first;
		prev      = line_first ? 8'd0 : cur_state.prev_char;

		next_state.in_line_comment  = line_cmt;
		next_state.in_block_comment = block_cmt;
		next_state.prev_char        = char_code;

		if (block_cmt && char_code == CH_SLASH) begin
			if (prev == CH_STAR) begin
				next_state.in_block_comment = 1'b0;
			end
			fg_class = CLS_COMMENT;
		end else if (line_cmt || block_cmt) begin
			fg_class = CLS_COMMENT;
		end else if (char_code == CH_SLASH) begin
			if (next_code == CH_SLASH) begin
				next_state.in_line_comment = 1'b1;
				fg_class = CLS_COMMENT;
			end else if (next_code == CH_STAR) begin
				next_state.in_block_comment = 1'b1;
				fg_class = CLS_COMMENT;
			end else begin
				fg_class = CLS_PUNCT;
			end
		end else if (punct) begin
			fg_class = CLS_PUNCT;
		end else begin
			fg_class = CLS_NORMAL;
		end
	end

endmodule

// ===== rtl/core/scc_select.sv =====
// ----------------------------------------------------------------------------
// scc_select
// Selection hit test: inclusive rectangle, or text-flow span when both
// the rows and the columns of the corners differ
// ----------------------------------------------------------------------------
module scc_select (
	input  scc_pkg::scc_sel_cfg_t sel_cfg,
	input  logic [15:0]           line_index,
	input  logic [15:0]           col_index,
	output logic                  selected
);
	import scc_pkg::*;

	logic rows_differ;
	logic cols_differ;
	logic in_box;
	logic in_flow;

	always_comb begin
		rows_differ = sel_cfg.end_row != sel_cfg.start_row;
		cols_differ = sel_cfg.end_col != sel_cfg.start_col;
		in_box = (line_index >= sel_cfg.start_row) && (line_index <= sel_cfg.end_row) &&
			(col_index >= sel_cfg.start_col) && (col_index <= sel_cfg.end_col);
		in_flow = rows_differ && cols_differ &&
			(((line_index == sel_cfg.start_row) && (col_index >= sel_cfg.start_col)) ||
			((line_index == sel_cfg.end_row) && (col_index <= sel_cfg.end_col)) ||
			((line_index < sel_cfg.end_row) && (line_index > sel_cfg.start_row)));
		// equal corners select nothing
		selected = (rows_differ || cols_differ) && (in_box || in_flow);
	end

endmodule

// ===== test/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// Watches the character, result and register channels of the classifier,
// predicts the class and selection bit of every accepted character and
// compares each result transfer against the oldest prediction
// ----------------------------------------------------------------------------
module scc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  scc_pkg::scc_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  scc_pkg::scc_out_t out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                mismatches,
	output int                outstanding
);
	import scc_pkg::*;

	scc_sel_cfg_t sel;
	logic         line_cmt;
	logic         block_cmt;
	logic [7:0]   last_char;
	scc_out_t     predicted_q[$];

	function automatic logic is_punct(input logic [7:0] c);
		return (c > 8'd32 && c < 8'd48) || (c > 8'd59 && c < 8'd63) ||
			(c > 8'd90 && c < 8'd95) || (c > 8'd122 && c < 8'd126);
	endfunction

	function automatic logic in_selection(input logic [15:0] row, input logic [15:0] col);
		logic rows_differ;
		logic cols_differ;
		logic box;
		logic flow;
		rows_differ = sel.end_row != sel.start_row;
		cols_differ = sel.end_col != sel.start_col;
		box = row >= sel.start_row && row <= sel.end_row &&
			col >= sel.start_col && col <= sel.end_col;
		// text-flow span only applies when both corners differ in row and column
		flow = rows_differ && cols_differ &&
			((row == sel.start_row && col >= sel.start_col) ||
			(row == sel.end_row && col <= sel.end_col) ||
			(row < sel.end_row && row > sel.start_row));
		return (rows_differ || cols_differ) && (box || flow);
	endfunction

	function automatic scc_out_t classify_char(input scc_in_t ch);
		scc_out_t r;
		if (ch.frame_first) begin
			line_cmt = 1'b0;
			block_cmt = 1'b0;
		end
		if (ch.line_first) begin
			line_cmt = 1'b0;
			last_char = 8'd0;
		end
		if (block_cmt && ch.char_code == CH_SLASH) begin
			if (last_char == CH_STAR)
				block_cmt = 1'b0;
			r.fg_class = CLS_COMMENT;
		end else if (line_cmt || block_cmt) begin
			r.fg_class = CLS_COMMENT;
		end else if (ch.char_code == CH_SLASH) begin
			r.fg_class = CLS_PUNCT;
			if (ch.next_code == CH_SLASH) begin
				line_cmt = 1'b1;
				r.fg_class = CLS_COMMENT;
			end else if (ch.next_code == CH_STAR) begin
				block_cmt = 1'b1;
				r.fg_class = CLS_COMMENT;
			end
		end else if (is_punct(ch.char_code)) begin
			r.fg_class = CLS_PUNCT;
		end else begin
			r.fg_class = CLS_NORMAL;
		end
		last_char = ch.char_code;
		r.selected = in_selection(ch.line_index, ch.col_index);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		scc_out_t want;
		scc_out_t pred;
		int errs;
		if (!arst_n) begin
			sel = '0;
			line_cmt = 1'b0;
			block_cmt = 1'b0;
			last_char = 8'd0;
			predicted_q.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			errs = mismatches;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SEL_START_ROW: sel.start_row = cfg_data;
					CFG_SEL_START_COL: sel.start_col = cfg_data;
					CFG_SEL_END_ROW:   sel.end_row = cfg_data;
					CFG_SEL_END_COL:   sel.end_col = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pred = classify_char(in_data);
				predicted_q = {predicted_q, pred};
			end
			if (out_valid && out_ready) begin
				if (predicted_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected result transfer: class %0d selected %0b",
							out_data.fg_class, out_data.selected);
				end else begin
					want = predicted_q.pop_front();
					if (out_data.fg_class !== want.fg_class ||
							out_data.selected !== want.selected) begin
						errs++;
						if (errs <= 10)
							$display({"result mismatch: class exp %0d got %0d, ",
								"selected exp %0b got %0b"},
								want.fg_class, out_data.fg_class, want.selected,
								out_data.selected);
					end
				end
			end
			mismatches <= errs;
			outstanding <= predicted_q.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the syntax color classifier with directed characters, then with
// random lines of code-like text and raw noise under several selection
// settings, with random idling on both channels, and reports the verdict
// ----------------------------------------------------------------------------
module testbench;
	import scc_pkg::*;

	localparam int LIMIT           = 200000;
	localparam int HOLD_CYCLES     = 150;
	localparam int ITEMS_PER_PHASE = 72;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	scc_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	scc_out_t    out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SEL_START_ROW;
	logic [15:0] cfg_data = 16'd0;

	int mismatches;
	int outstanding;
	int cycles = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_hold = 1'b0;

	always #5 clk = ~clk;

	syntax_color_classifier_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	scc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stall per transfer, stretches with ready held high
	initial begin : sink
		int stall;
		int left;
		left = 0;
		wait (arst_n);
		forever begin
			if (left == 0) begin
				rx_burst = !rx_burst;
				left = $urandom_range(10, 40);
			end
			left--;
			if (rx_hold) begin
				stall = HOLD_CYCLES;
				rx_hold = 1'b0;
			end else begin
				stall = rx_burst ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic put_char(input scc_in_t ch);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic char_at(input logic [7:0] c, input logic [7:0] nx, input logic [15:0] row,
			input logic [15:0] col, input logic frame, input logic line);
		scc_in_t ch;
		ch.char_code = c;
		ch.next_code = nx;
		ch.line_index = row;
		ch.col_index = col;
		ch.frame_first = frame;
		ch.line_first = line;
		put_char(ch);
	endtask

	task automatic put_noise();
		logic [63:0] raw;
		scc_in_t ch;
		raw = {$urandom, $urandom};
		ch = raw[$bits(scc_in_t)-1:0];
		put_char(ch);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 15))
			0, 1, 2, 3: return CH_SLASH;
			4, 5, 6:    return CH_STAR;
			7:          return 8'd32;
			8:          return 8'($urandom_range(33, 47));
			9:          return 8'($urandom_range(58, 64));
			10:         return 8'($urandom_range(89, 96));
			11:         return 8'($urandom_range(121, 127));
			12:         return 8'($urandom_range(48, 57));
			13:         return 8'($urandom_range(0, 255));
			default:    return 8'($urandom_range(97, 122));
		endcase
	endfunction

	// one well-formed line: next_code follows the text, 0 after the last char
	task automatic send_line(input logic [15:0] row, input logic [15:0] col0,
			input logic frame_start, output int len);
		logic [7:0] txt [0:11];
		scc_in_t ch;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			txt[i] = pick_char();
		tx_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			ch.char_code = txt[i];
			ch.next_code = (i + 1 < len) ? txt[i + 1] : 8'd0;
			ch.line_index = row;
			ch.col_index = 16'(col0 + i);
			ch.frame_first = frame_start && (i == 0);
			ch.line_first = (i == 0);
			put_char(ch);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_selection(input logic [15:0] sr, input logic [15:0] sc,
			input logic [15:0] er, input logic [15:0] ec);
		write_reg(CFG_SEL_START_ROW, sr);
		write_reg(CFG_SEL_START_COL, sc);
		write_reg(CFG_SEL_END_ROW, er);
		write_reg(CFG_SEL_END_COL, ec);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [15:0] row;
		logic [15:0] col0;
		int n;
		int len;
		wait (arst_n);
		@(posedge clk);

		// field extremes
		char_at(8'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		char_at(8'd255, 8'd255, 16'hffff, 16'hffff, 1'b0, 1'b0);
		// lone slash with nothing after it stays punctuation
		char_at(CH_SLASH, 8'd0, 16'd1, 16'd0, 1'b0, 1'b1);
		// line comment, cleared by the next line
		char_at(CH_SLASH, CH_SLASH, 16'd2, 16'd0, 1'b0, 1'b1);
		char_at("a", 8'd0, 16'd2, 16'd1, 1'b0, 1'b0);
		char_at("b", 8'd0, 16'd3, 16'd0, 1'b0, 1'b1);
		// block comment opened and closed by star-slash
		char_at(CH_SLASH, CH_STAR, 16'd3, 16'd1, 1'b0, 1'b0);
		char_at(CH_STAR, CH_SLASH, 16'd3, 16'd2, 1'b0, 1'b0);
		char_at(CH_SLASH, 8'd0, 16'd3, 16'd3, 1'b0, 1'b0);
		char_at("x", 8'd0, 16'd3, 16'd4, 1'b0, 1'b0);
		// star at line end does not close with a slash on the next line
		char_at(CH_SLASH, CH_STAR, 16'd3, 16'd5, 1'b0, 1'b0);
		char_at(CH_STAR, 8'd0, 16'd3, 16'd6, 1'b0, 1'b0);
		char_at(CH_SLASH, 8'd0, 16'd4, 16'd0, 1'b0, 1'b1);
		char_at("q", CH_SLASH, 16'd4, 16'd1, 1'b0, 1'b0);
		char_at(CH_SLASH, 8'd0, 16'd4, 16'd2, 1'b0, 1'b0);
		// frame flag alone clears the block comment
		char_at(CH_STAR, 8'd0, 16'd4, 16'd3, 1'b0, 1'b0);
		char_at(CH_SLASH, 8'd0, 16'd4, 16'd4, 1'b1, 1'b0);
		// class boundaries
		char_at(8'd32, 8'd0, 16'd5, 16'd0, 1'b0, 1'b1);
		char_at(8'd33, 8'd0, 16'd5, 16'd1, 1'b0, 1'b0);
		char_at(8'd48, 8'd0, 16'd5, 16'd2, 1'b0, 1'b0);
		char_at(8'd62, 8'd0, 16'd5, 16'd3, 1'b0, 1'b0);
		char_at(8'd95, 8'd0, 16'd5, 16'd4, 1'b0, 1'b0);
		char_at(8'd125, 8'd0, 16'd5, 16'd5, 1'b0, 1'b0);
		char_at(8'd126, 8'd0, 16'd5, 16'd6, 1'b0, 1'b0);
		drain();

		for (int phase = 1; phase <= 7; phase++) begin
			case (phase)
				1: set_selection(16'd2, 16'd3, 16'd6, 16'd8);
				2: set_selection(16'd0, 16'd0, 16'hffff, 16'hffff);
				3: set_selection(16'd4, 16'd2, 16'd4, 16'd9);
				4: set_selection(16'd7, 16'd5, 16'd3, 16'd1);
				5: set_selection(16'hffff, 16'hffff, 16'd0, 16'd0);
				6: set_selection(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
					16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
				default: set_selection(16'd5, 16'd5, 16'd5, 16'd5);
			endcase
			n = 0;
			if (phase == 3) begin
				// receiver holds off while characters keep coming back to back
				rx_hold = 1'b1;
				tx_burst = 1'b1;
				repeat (30) put_noise();
				n = 30;
			end
			while (n < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) == 0) begin
					tx_burst = ($urandom_range(0, 3) == 0);
					put_noise();
					n++;
				end else begin
					case ($urandom_range(0, 9))
						0:       row = 16'($urandom);
						1:       row = 16'($urandom_range(65530, 65535));
						default: row = 16'($urandom_range(0, 12));
					endcase
					col0 = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(65530, 65535))
						: 16'($urandom_range(0, 10));
					send_line(row, col0, $urandom_range(0, 5) == 0, len);
					n += len;
				end
			end
			drain();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
